// ----- rtl/rphf_pkg.sv -----
// Shared constants for the half-precision round-and-pack unit.
`default_nettype none

package rphf_pkg;

    localparam int SIG_W   = 16;
    localparam int EXP_W   = 8;
    localparam int HALF_W  = 16;
    localparam int DIST_W  = 5;
    localparam int RBITS_W = 4;
    localparam int MODE_W  = 3;
    localparam int FRAC_W  = 13;

    // Rounding modes; the two unused codes round toward zero.
    localparam logic [MODE_W-1:0] MODE_NEAR_EVEN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TOWARD_ZERO = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UP          = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEAR_AWAY   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ODD         = 3'd5;

    // Configuration register indexes.
    localparam logic REG_ROUNDING_MODE = 1'b0;
    localparam logic REG_TININESS      = 1'b1;

    localparam logic [RBITS_W-1:0] INC_NEAR = 4'h8;
    localparam logic [RBITS_W-1:0] INC_AWAY = 4'hF;
    localparam logic [RBITS_W-1:0] RBITS_HALF = 4'h8;

    localparam logic signed [EXP_W-1:0] EXP_MAX = 8'sh1D;
    localparam logic [SIG_W:0]          SIG_OVF = 17'h08000;
    localparam logic [DIST_W-1:0]       DIST_SAT = 5'd16;
    localparam logic [HALF_W-1:0]       INF_BITS = 16'h7C00;

endpackage

`default_nettype wire

// ----- rtl/rphf_sticky_shift.sv -----
// Sticky right shift of the significand for denormal results.
`default_nettype none

module rphf_sticky_shift (
    input  wire logic [rphf_pkg::SIG_W-1:0]  sig,
    input  wire logic [rphf_pkg::DIST_W-1:0] shamt,
    output logic      [rphf_pkg::SIG_W-1:0]  shifted
);

    logic [rphf_pkg::SIG_W-1:0] lost_mask;
    logic                       lost;

    // Distances of 16 and beyond collapse to a single sticky bit.
    always_comb
    begin
        lost_mask = ~({rphf_pkg::SIG_W{1'b1}} << shamt);
        lost      = |(sig & lost_mask);
        shifted   = (sig >> shamt) | {{(rphf_pkg::SIG_W-1){1'b0}}, lost};
    end

endmodule

`default_nettype wire

// ----- rtl/round_pack_half_float_unit.sv -----
// Top level of the half-precision round-and-pack unit.
// Usage:
//   Pulse start with sign_bit, exponent and significand; a request is taken at
//   every rising edge where start is high and busy is low. busy stays low, so
//   a new request may enter in every cycle.
//   The packed word and its inexact, underflow and overflow flags appear on
//   half_word and the flag ports, for one cycle, marked by done.
//   Results leave in request order. Throughput is one request per cycle; the
//   pipe has three register stages: decode and range check, sticky
//   denormalizing shift, then round increment and pack.
//   The receiver cannot hold results off, so nothing stalls in the pipe.
//   Configuration: cfg_write with cfg_index 0 writes rounding_mode, index 1
//   writes tininess_before_rounding (bit 0 of cfg_data). Write only while no
//   request is in flight.
//   Reset clears the pipe's valid bits and sets both registers to zero
//   (round to nearest even, tininess after rounding).
`default_nettype none

module round_pack_half_float_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                sign_bit,
    input  wire logic signed [rphf_pkg::EXP_W-1:0]   exponent,
    input  wire logic        [rphf_pkg::SIG_W-1:0]   significand,
    input  wire logic                                cfg_write,
    input  wire logic                                cfg_index,
    input  wire logic        [rphf_pkg::MODE_W-1:0]  cfg_data,
    output logic                                     done,
    output logic             [rphf_pkg::HALF_W-1:0]  half_word,
    output logic                                     inexact,
    output logic                                     underflow,
    output logic                                     overflow
);

    typedef struct packed {
        logic                           sgn;
        logic [4:0]                     ex;
        logic [rphf_pkg::SIG_W-1:0]     sig;
        logic [rphf_pkg::RBITS_W-1:0]   inc;
        logic [rphf_pkg::DIST_W-1:0]    shamt;
        logic                           tiny;
        logic                           ovf;
        logic                           odd;
        logic                           near_even;
    } s1_t;

    typedef struct packed {
        logic                           sgn;
        logic [4:0]                     ex;
        logic [rphf_pkg::SIG_W-1:0]     sig;
        logic [rphf_pkg::RBITS_W-1:0]   inc;
        logic                           under;
        logic                           ovf;
        logic                           odd;
        logic                           near_even;
    } s2_t;

    logic [rphf_pkg::MODE_W-1:0] mode_reg;
    logic                        tbr_reg;

    logic s1_valid_reg, s2_valid_reg, done_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic [rphf_pkg::HALF_W-1:0] word_reg, word_next;
    logic inexact_reg, inexact_next;
    logic under_reg, under_next;
    logic over_reg, over_next;

    logic accept;
    logic [rphf_pkg::SIG_W-1:0] shifted;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rphf_pkg::MODE_NEAR_EVEN;
            tbr_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rphf_pkg::REG_ROUNDING_MODE: mode_reg <= cfg_data;
                rphf_pkg::REG_TININESS:      tbr_reg  <= cfg_data[0];
                default:                     mode_reg <= mode_reg;
            endcase
        end
    end

    // Stage 1: round increment, tininess and overflow check, shift distance.
    always_comb
    begin
        logic                        near;
        logic                        dir_up;
        logic [rphf_pkg::SIG_W:0]    sig_inc;
        logic [rphf_pkg::EXP_W-1:0]  neg_ex;
        logic                        is_neg;

        near    = (mode_reg == rphf_pkg::MODE_NEAR_EVEN) ||
                  (mode_reg == rphf_pkg::MODE_NEAR_AWAY);
        dir_up  = (mode_reg == (sign_bit ? rphf_pkg::MODE_DOWN : rphf_pkg::MODE_UP));
        is_neg  = exponent[rphf_pkg::EXP_W-1];
        neg_ex  = 8'd0 - exponent;

        s1_next.sgn = sign_bit;
        s1_next.sig = significand;
        if (near)
            s1_next.inc = rphf_pkg::INC_NEAR;
        else if (dir_up)
            s1_next.inc = rphf_pkg::INC_AWAY;
        else
            s1_next.inc = '0;

        sig_inc = {1'b0, significand} + {13'd0, s1_next.inc};

        s1_next.ex   = is_neg ? 5'd0 : exponent[4:0];
        if (!is_neg)
            s1_next.shamt = '0;
        else if (neg_ex > {3'd0, rphf_pkg::DIST_SAT})
            s1_next.shamt = rphf_pkg::DIST_SAT;
        else
            s1_next.shamt = neg_ex[rphf_pkg::DIST_W-1:0];

        s1_next.tiny = is_neg && (tbr_reg || (exponent < -8'sd1) ||
                                  (sig_inc < rphf_pkg::SIG_OVF));
        s1_next.ovf  = !is_neg && ((exponent > rphf_pkg::EXP_MAX) ||
                       ((exponent == rphf_pkg::EXP_MAX) && (sig_inc >= rphf_pkg::SIG_OVF)));
        s1_next.odd       = (mode_reg == rphf_pkg::MODE_ODD);
        s1_next.near_even = (mode_reg == rphf_pkg::MODE_NEAR_EVEN);
    end

    // Stage 2: denormalize.
    rphf_sticky_shift u_shift (
        .sig     (s1_reg.sig),
        .shamt   (s1_reg.shamt),
        .shifted (shifted)
    );

    always_comb
    begin
        s2_next.sgn       = s1_reg.sgn;
        s2_next.ex        = s1_reg.ex;
        s2_next.sig       = shifted;
        s2_next.inc       = s1_reg.inc;
        s2_next.under     = s1_reg.tiny && (shifted[rphf_pkg::RBITS_W-1:0] != '0);
        s2_next.ovf       = s1_reg.ovf;
        s2_next.odd       = s1_reg.odd;
        s2_next.near_even = s1_reg.near_even;
    end

    // Stage 3: round increment and pack; the field sum wraps at 16 bits.
    always_comb
    begin
        logic [rphf_pkg::SIG_W:0]       sum;
        logic [rphf_pkg::FRAC_W-1:0]    frac;
        logic [4:0]                     ex;
        logic [rphf_pkg::RBITS_W-1:0]   rbits;
        logic [rphf_pkg::HALF_W-1:0]    sgn_bits;

        rbits    = s2_reg.sig[rphf_pkg::RBITS_W-1:0];
        sum      = {1'b0, s2_reg.sig} + {13'd0, s2_reg.inc};
        frac     = sum[rphf_pkg::SIG_W:rphf_pkg::RBITS_W];
        ex       = s2_reg.ex;
        sgn_bits = {s2_reg.sgn, 15'd0};

        priority if (s2_reg.ovf)
        begin
            word_next    = sgn_bits + rphf_pkg::INF_BITS -
                           {15'd0, (s2_reg.inc == '0)};
            inexact_next = 1'b1;
            under_next   = 1'b0;
            over_next    = 1'b1;
        end
        else
        begin
            if ((rbits != '0) && s2_reg.odd)
                frac = frac | 13'd1;
            else
            begin
                if (s2_reg.near_even && (rbits == rphf_pkg::RBITS_HALF))
                    frac = frac & ~13'd1;
                if (frac == '0)
                    ex = '0;
            end
            word_next    = sgn_bits + {1'b0, ex, 10'd0} + {3'd0, frac};
            inexact_next = (rbits != '0);
            under_next   = s2_reg.under;
            over_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        word_reg    <= word_next;
        inexact_reg <= inexact_next;
        under_reg   <= under_next;
        over_reg    <= over_next;
    end

    assign done      = done_reg;
    assign half_word = word_reg;
    assign inexact   = inexact_reg;
    assign underflow = under_reg;
    assign overflow  = over_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request did not produce a result three cycles later");

    a_over_inexact: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> inexact)
        else $error("overflow without inexact");

    a_under_inexact: assert property (@(posedge clk) disable iff (!rst_n)
        (done && underflow) |-> (inexact && !overflow))
        else $error("underflow without inexact or with overflow");

    a_over_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (half_word[14:0] == 15'h7C00 ||
                                half_word[14:0] == 15'h7BFF))
        else $error("overflow result is neither infinity nor largest finite");

    a_ovf_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.ovf) |-> (s1_reg.shamt == '0 && !s1_reg.tiny))
        else $error("overflowing request was marked for denormalization");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the half-precision round-and-pack unit: directed and random requests.
`default_nettype none

module tb_top;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PER_SETTING  = 75;

    typedef struct packed {
        logic [rphf_pkg::HALF_W-1:0] word;
        logic                        inexact;
        logic                        underflow;
        logic                        overflow;
    } rounded_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic                                sign_bit = 1'b0;
    logic signed [rphf_pkg::EXP_W-1:0]   exponent = '0;
    logic        [rphf_pkg::SIG_W-1:0]   significand = '0;
    logic                                cfg_write = 1'b0;
    logic                                cfg_index = rphf_pkg::REG_ROUNDING_MODE;
    logic        [rphf_pkg::MODE_W-1:0]  cfg_data = '0;
    logic                                done;
    logic        [rphf_pkg::HALF_W-1:0]  half_word;
    logic                                inexact;
    logic                                underflow;
    logic                                overflow;

    logic [rphf_pkg::MODE_W-1:0] cur_mode = rphf_pkg::MODE_NEAR_EVEN;
    logic                        cur_tin = 1'b0;
    rounded_t                    expected_words[$];
    rounded_t                    want;
    int                          n_requests = 0;
    int                          n_checked = 0;
    int                          n_errors = 0;
    int                          cycle_count = 0;

    round_pack_half_float_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sign_bit    (sign_bit),
        .exponent    (exponent),
        .significand (significand),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .half_word   (half_word),
        .inexact     (inexact),
        .underflow   (underflow),
        .overflow    (overflow)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic [rphf_pkg::HALF_W-1:0] pack_fields(input int unsigned s,
                                                                input int unsigned ex,
                                                                input int unsigned frac);
        int unsigned sum;
        sum = (s << 15) + (ex << 10) + frac;
        return sum[rphf_pkg::HALF_W-1:0];
    endfunction

    // Round a significand with four guard bits to ten fraction bits and pack it.
    function automatic rounded_t round_half(input logic s,
                                            input logic signed [rphf_pkg::EXP_W-1:0] e,
                                            input logic [rphf_pkg::SIG_W-1:0] g,
                                            input logic [rphf_pkg::MODE_W-1:0] mode,
                                            input logic tin);
        int unsigned inc;
        int unsigned rbits;
        int unsigned sg;
        int unsigned shamt;
        int unsigned sat;
        int          ex;
        logic        tiny;
        rounded_t    r;
        r = '0;
        ex = int'(e);
        sg = 32'(g);
        if (mode == rphf_pkg::MODE_NEAR_EVEN || mode == rphf_pkg::MODE_NEAR_AWAY)
            inc = 32'(rphf_pkg::INC_NEAR);
        else if (mode == (s ? rphf_pkg::MODE_DOWN : rphf_pkg::MODE_UP))
            inc = 32'(rphf_pkg::INC_AWAY);
        else
            inc = 0;
        rbits = sg & 32'hF;
        if (ex < 0)
        begin
            tiny = tin || (ex < -1) || (sg + inc < 32'h8000);
            shamt = 32'(-ex);
            // sticky shift: any bit shifted out lands in bit 0
            if (shamt >= 31)
                sg = 32'(sg != 0);
            else if (shamt != 0)
                sg = (sg >> shamt) | 32'((sg << (32 - shamt)) != 0);
            ex = 0;
            rbits = sg & 32'hF;
            if (tiny && rbits != 0)
                r.underflow = 1'b1;
        end
        else if (ex > 29 || (ex == 29 && sg + inc >= 32'h8000))
        begin
            r.overflow = 1'b1;
            r.inexact = 1'b1;
            // infinity, or the largest finite value when the mode gives no round increment
            sat = (32'(s) << 15) + 32'h7C00 - ((inc == 0) ? 32'd1 : 32'd0);
            r.word = sat[rphf_pkg::HALF_W-1:0];
            return r;
        end
        sg = (sg + inc) >> 4;
        if (rbits != 0)
        begin
            r.inexact = 1'b1;
            if (mode == rphf_pkg::MODE_ODD)
            begin
                r.word = pack_fields(32'(s), 32'(ex), sg | 32'd1);
                return r;
            end
        end
        if (mode == rphf_pkg::MODE_NEAR_EVEN && rbits == 32'(rphf_pkg::RBITS_HALF))
            sg = sg & ~32'h1;
        if (sg == 0)
            ex = 0;
        r.word = pack_fields(32'(s), 32'(ex), sg);
        return r;
    endfunction

    task automatic send_request(input logic s, input logic signed [rphf_pkg::EXP_W-1:0] e,
                                input logic [rphf_pkg::SIG_W-1:0] g);
        start <= 1'b1;
        sign_bit <= s;
        exponent <= e;
        significand <= g;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_words.push_back(round_half(s, e, g, cur_mode, cur_tin));
        n_requests++;
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drain the pipe, then write both registers back to back.
    task automatic apply_config(input logic [rphf_pkg::MODE_W-1:0] mode, input logic tin);
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= rphf_pkg::REG_ROUNDING_MODE;
        cfg_data <= mode;
        @(posedge clk);
        cfg_index <= rphf_pkg::REG_TININESS;
        cfg_data <= {{(rphf_pkg::MODE_W-1){1'b0}}, tin};
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_mode = mode;
        cur_tin = tin;
    endtask

    task automatic test_directed();
        apply_config(rphf_pkg::MODE_NEAR_EVEN, 1'b0);
        send_request(1'b0, 8'sh00, 16'h0000);
        send_request(1'b1, 8'sh80, 16'hFFFF);
        send_request(1'b0, 8'sh7F, 16'hFFFF);
        send_request(1'b0, 8'sh1D, 16'h7FF8);
        send_request(1'b1, 8'sh10, 16'h7FF8);
        send_request(1'b0, 8'sh0F, 16'hFFFF);
        send_request(1'b0, -8'sd1, 16'h7FF8);
        send_request(1'b1, -8'sd31, 16'h4001);
        send_request(1'b0, 8'sh05, 16'h4018);
        // overflow in every mode, both signs, including the two unused codes
        for (int m = 0; m < 8; m++)
        begin
            apply_config(rphf_pkg::MODE_W'(m), m[0]);
            send_request(1'b0, 8'sh1E, 16'h4008);
            send_request(1'b1, 8'sh1E, 16'h4008);
        end
    endtask

    task automatic run_phase(input int pct);
        logic                              s;
        logic signed [rphf_pkg::EXP_W-1:0] e;
        logic        [rphf_pkg::SIG_W-1:0] g;
        for (int k = 0; k < 8; k++)
        begin
            apply_config(rphf_pkg::MODE_W'(k), 1'($urandom_range(1)));
            for (int n = 0; n < PER_SETTING; n++)
            begin
                s = 1'($urandom_range(1));
                case ($urandom_range(3))
                    0: e = rphf_pkg::EXP_W'($urandom_range(255));
                    1: e = rphf_pkg::EXP_W'(27 + $urandom_range(4));
                    2: e = rphf_pkg::EXP_W'(0 - $urandom_range(20));
                    default: e = rphf_pkg::EXP_W'($urandom_range(26, 1));
                endcase
                case ($urandom_range(3))
                    0: g = rphf_pkg::SIG_W'($urandom_range(65535));
                    1: g = rphf_pkg::SIG_W'(32'h4000 | $urandom_range(16'h3FFF));
                    2: g = rphf_pkg::SIG_W'(32'h7FF0 | $urandom_range(15));
                    default: g = rphf_pkg::SIG_W'($urandom_range(255) << $urandom_range(8));
                endcase
                idle_gap(pct);
                send_request(s, e, g);
            end
        end
    endtask

    task automatic test_back_to_back();
        run_phase(0);
    endtask

    task automatic test_sparse_requests();
        run_phase(70);
    endtask

    task automatic test_light_idle();
        run_phase(11);
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result half_word=%h inexact=%b",
                         $time, half_word, inexact);
                $display("    underflow=%b overflow=%b", underflow, overflow);
                n_errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                n_checked++;
                if ({half_word, inexact, underflow, overflow} !== want)
                begin
                    $display("%0t: mismatch expected word=%h ix=%b uf=%b of=%b,",
                             $time, want.word, want.inexact, want.underflow,
                             want.overflow);
                    $display("    got word=%h ix=%b uf=%b of=%b",
                             half_word, inexact, underflow, overflow);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_words.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_to_back();
        test_sparse_requests();
        test_light_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests over all eight mode codes, both tininess settings",
                 n_requests);
        $display("and three request-spacing profiles; %0d results checked, %0d errors",
                 n_checked, n_errors);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
